[sv/pwd_pkg.sv]
// ----------------------------------------------------------------------------
// pwd_pkg
// Types and constants for the PID controller with error deadband.
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int ERR_WIDTH  = DATA_WIDTH + 1;
  localparam int DER_WIDTH  = DATA_WIDTH + 2;
  localparam int SUM_WIDTH  = 32;
  localparam int GAIN_WIDTH = DATA_WIDTH;
  localparam int DB_WIDTH   = DATA_WIDTH - 1;
  localparam int P_WIDTH    = GAIN_WIDTH + 1 + ERR_WIDTH;
  localparam int I_WIDTH    = GAIN_WIDTH + 1 + SUM_WIDTH;
  localparam int D_WIDTH    = GAIN_WIDTH + 1 + DER_WIDTH;
  localparam int ACC_WIDTH  = I_WIDTH + 2;
  localparam int CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DEADBAND  = 3'd3,
    REG_DRIVE_MIN = 3'd4,
    REG_DRIVE_MAX = 3'd5
  } cfg_reg_t;

  localparam logic [GAIN_WIDTH-1:0] GAIN_P_RESET = 16'd512;
  localparam logic [GAIN_WIDTH-1:0] GAIN_I_RESET = 16'd26;
  localparam logic [GAIN_WIDTH-1:0] GAIN_D_RESET = 16'd256;
  localparam logic [DB_WIDTH-1:0]   DEADBAND_RESET = 15'd128;
  localparam logic signed [DATA_WIDTH-1:0] DRIVE_MIN_RESET = 16'sd0;
  localparam logic signed [DATA_WIDTH-1:0] DRIVE_MAX_RESET = 16'sd12800;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;
    logic                         clear_accumulator;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         in_deadband;
    logic                         clamped;
  } result_t;

endpackage

[sv/pid_with_deadband.sv]
// ----------------------------------------------------------------------------
// pid_with_deadband
// Fixed-point PID controller with an error deadband and clamped drive.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless result_stall holds the pipeline, and
// returns one result per sample through the input register, error/integral
// stage, multiply stage and sum/clamp stage. The error stage updates the
// integral and last-error state, closing the feedback loop before the next
// sample enters it. Unknown cfg indexes are ignored. Gains and limits are
// to be written through the cfg port while no sample is in flight; unchecked.
module pid_with_deadband
  import pwd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  sample_t                   sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_write_en,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0]     cfg_data
);

  logic [GAIN_WIDTH-1:0]         gain_p, gain_i, gain_d;
  logic [DB_WIDTH-1:0]           deadband;
  logic signed [DATA_WIDTH-1:0]  drive_min, drive_max;

  logic signed [SUM_WIDTH-1:0]   error_sum;
  logic signed [ERR_WIDTH-1:0]   last_error;

  logic                          v0, v1, v2;
  sample_t                       in0;
  logic                          rdy0, rdy1, rdy2, rdy3;

  logic signed [ERR_WIDTH-1:0]   err;
  logic        [ERR_WIDTH-1:0]   err_mag;
  logic                          db_hit;
  logic signed [SUM_WIDTH-1:0]   sum_base;
  logic signed [SUM_WIDTH:0]     sum_wide;
  logic signed [SUM_WIDTH-1:0]   error_sum_next;
  logic signed [DER_WIDTH-1:0]   deriv;

  logic signed [ERR_WIDTH-1:0]   s1_err;
  logic signed [SUM_WIDTH-1:0]   s1_sum;
  logic signed [DER_WIDTH-1:0]   s1_deriv;
  logic                          s1_db;

  logic signed [P_WIDTH-1:0]     s2_p;
  logic signed [I_WIDTH-1:0]     s2_i;
  logic signed [D_WIDTH-1:0]     s2_d;
  logic                          s2_db;

  logic signed [ACC_WIDTH-1:0]   acc;
  logic signed [ACC_WIDTH-1:0]   drv_wide;
  logic signed [ACC_WIDTH-1:0]   max_wide, min_wide;
  logic signed [ACC_WIDTH-1:0]   drv_a, drv_b;
  logic                          hit_max, hit_min;

  logic                          take_in, adv1;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= GAIN_P_RESET;
      gain_i    <= GAIN_I_RESET;
      gain_d    <= GAIN_D_RESET;
      deadband  <= DEADBAND_RESET;
      drive_min <= DRIVE_MIN_RESET;
      drive_max <= DRIVE_MAX_RESET;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:    gain_p    <= cfg_data;
        REG_GAIN_I:    gain_i    <= cfg_data;
        REG_GAIN_D:    gain_d    <= cfg_data;
        REG_DEADBAND:  deadband  <= cfg_data[DB_WIDTH-1:0];
        REG_DRIVE_MIN: drive_min <= $signed(cfg_data);
        REG_DRIVE_MAX: drive_max <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign rdy3 = !result_valid || !result_stall;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign sample_stall = !rdy0;
  assign take_in = sample_valid && rdy0;
  assign adv1 = v0 && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy0) v0 <= sample_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) in0 <= sample;
  end

  // error, deadband, integral
  always_comb begin
    err      = ERR_WIDTH'(in0.target) - ERR_WIDTH'(in0.measured);
    err_mag  = err[ERR_WIDTH-1] ? ERR_WIDTH'(-err) : ERR_WIDTH'(err);
    db_hit   = err_mag <= ERR_WIDTH'(deadband);
    sum_base = in0.clear_accumulator ? '0 : error_sum;
    sum_wide = (SUM_WIDTH+1)'(sum_base) + (SUM_WIDTH+1)'(err);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
      error_sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    else
      error_sum_next = sum_wide[SUM_WIDTH-1:0];
    deriv = DER_WIDTH'(err) - DER_WIDTH'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (adv1) begin
      error_sum  <= db_hit ? '0 : error_sum_next;
      last_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_err   <= err;
      s1_sum   <= error_sum_next;
      s1_deriv <= deriv;
      s1_db    <= db_hit;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2_p  <= P_WIDTH'($signed({1'b0, gain_p})) * P_WIDTH'(s1_err);
      s2_i  <= I_WIDTH'($signed({1'b0, gain_i})) * I_WIDTH'(s1_sum);
      s2_d  <= D_WIDTH'($signed({1'b0, gain_d})) * D_WIDTH'(s1_deriv);
      s2_db <= s1_db;
    end
  end

  // sum, scale, clamp
  always_comb begin
    acc      = ACC_WIDTH'(s2_p) + ACC_WIDTH'(s2_i) + ACC_WIDTH'(s2_d);
    drv_wide = acc >>> FRAC_BITS;
    max_wide = ACC_WIDTH'(drive_max);
    min_wide = ACC_WIDTH'(drive_min);
    hit_max  = drv_wide > max_wide;
    drv_a    = hit_max ? max_wide : drv_wide;
    hit_min  = drv_a < min_wide;
    drv_b    = hit_min ? min_wide : drv_a;
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      result.drive       <= s2_db ? '0 : drv_b[DATA_WIDTH-1:0];
      result.in_deadband <= s2_db;
      result.clamped     <= !s2_db && (hit_max || hit_min);
    end
  end

  // checks
  a_db_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.in_deadband |-> result.drive == '0 && !result.clamped)
    else $error("deadband result with nonzero drive or clamp");

  a_db_clears_sum: assert property (@(posedge clk) disable iff (rst)
    adv1 && db_hit |=> error_sum == '0)
    else $error("integral not cleared in deadband");

  a_last_error: assert property (@(posedge clk) disable iff (rst)
    adv1 |=> last_error == $past(err))
    else $error("last error not updated");

endmodule
